// ===== hdl/cfs_pkg.sv =====
// ----------------------------------------------------------------------------
// cfs_pkg: shared types and constants for the camera follow smoother
// Widths, operation codes, sequencer states and unit request structs.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int CAM_W      = 24;
  localparam int MAG_W      = 25;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int REM_W      = MAG_W + 3;
  localparam int ITER_STEPS = MAG_W;
  localparam int CNT_W      = 5;
  localparam int BOUND_W    = 23;
  localparam int SCALE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam logic [CAM_W-2:0] CAM_MAX = '1;

  // Division by 20 and by 100 of a value below 2^25: drop two bits, then
  // multiply by a rounded-up reciprocal and shift. Both are exact over the
  // 23-bit range that is left after the first shift.
  localparam int               DIV20_SHIFT  = 26;
  localparam int               DIV100_SHIFT = 28;
  localparam logic [MAG_W-1:0] RECIP_5      = 25'd13421773;
  localparam logic [MAG_W-1:0] RECIP_25     = 25'd10737419;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SNAP  = 2'd1,
    OP_TRANS = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLAMP_X = 3'd0,
    REG_CLAMP_Y = 3'd1,
    REG_BOUND_X = 3'd2,
    REG_BOUND_Y = 3'd3,
    REG_SCALE_X = 3'd4,
    REG_SCALE_Y = 3'd5,
    REG_HALF_X  = 3'd6,
    REG_HALF_Y  = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    MODE_DIV  = 1'b0,
    MODE_SQRT = 1'b1
  } iter_mode_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_STS, ST_WS, ST_DIV20, ST_DIV100, ST_STEP,
    ST_MULX, ST_STX, ST_WX, ST_MULY, ST_STY, ST_WY, ST_ENDC,
    ST_CLX, ST_CLXC, ST_CLY, ST_CLYC, ST_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    iter_mode_e        mode;
    logic [PROD_W-1:0] num;
    logic [MAG_W-1:0]  den;
  } iter_req_t;

  typedef struct packed {
    logic             en;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
  } mul_req_t;

endpackage

// ===== hdl/cfs_if.sv =====
// ----------------------------------------------------------------------------
// cfs_if: channel interfaces of the camera follow smoother
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface cfs_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       op;
  logic signed [cfs_pkg::CAM_W-1:0] target_x;
  logic signed [cfs_pkg::CAM_W-1:0] target_y;
  modport source (output valid, op, target_x, target_y, input ready);
  modport sink   (input valid, op, target_x, target_y, output ready);
endinterface

interface cfs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [cfs_pkg::CAM_W-1:0] camera_x;
  logic signed [cfs_pkg::CAM_W-1:0] camera_y;
  logic                             in_transition;
  modport source (output valid, camera_x, camera_y, in_transition, input ready);
  modport sink   (input valid, camera_x, camera_y, in_transition, output ready);
endinterface

interface cfs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cfs_pkg::CFG_IDX_W-1:0]     index;
  logic [cfs_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/cfs_mul.sv =====
// ----------------------------------------------------------------------------
// cfs_mul: shared unsigned multiplier
// One registered 25 by 25 bit product, loaded when requested.
// ----------------------------------------------------------------------------
module cfs_mul (
  input  logic                       clk_i,
  input  cfs_pkg::mul_req_t          req_i,
  output logic [cfs_pkg::PROD_W-1:0] p_o
);

  logic [cfs_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      p_q <= req_i.a * req_i.b;
    end
  end

  assign p_o = p_q;

endmodule

// ===== hdl/cfs_iter.sv =====
// ----------------------------------------------------------------------------
// cfs_iter: shared iterative square root and divide unit
// One quotient or root bit per cycle through a single subtractor.
// ----------------------------------------------------------------------------
module cfs_iter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfs_pkg::iter_req_t        req_i,
  output logic                      done_o,
  output logic [cfs_pkg::MAG_W-1:0] q_o
);

  localparam int MW = cfs_pkg::MAG_W;
  localparam int RW = cfs_pkg::REM_W;
  localparam int PW = cfs_pkg::PROD_W;

  logic                      busy_q, done_q;
  logic [cfs_pkg::CNT_W-1:0] cnt_q;
  cfs_pkg::iter_mode_e       mode_q;
  logic [MW-1:0]             den_q;
  logic [RW-1:0]             rem_q;
  logic [PW-1:0]             num_q;
  logic [MW-1:0]             q_q;

  logic [RW-1:0] rem_sh, trial;
  logic [RW:0]   diff;
  logic          ge;

  always_comb begin
    if (mode_q == cfs_pkg::MODE_SQRT) begin
      rem_sh = {rem_q[RW-3:0], num_q[PW-1:PW-2]};
      trial  = {1'b0, q_q, 2'b01};
    end else begin
      rem_sh = {rem_q[RW-2:0], num_q[PW-1]};
      trial  = {3'b000, den_q};
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    ge   = ~diff[RW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == cfs_pkg::CNT_W'(cfs_pkg::ITER_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.mode;
      den_q  <= req_i.den;
      q_q    <= '0;
      if (req_i.mode == cfs_pkg::MODE_SQRT) begin
        rem_q <= '0;
        num_q <= req_i.num;
      end else begin
        // The quotient fits in MAG_W bits, so the upper half seeds the remainder.
        rem_q <= {3'b000, req_i.num[PW-1:MW]};
        num_q <= {req_i.num[MW-1:0], {MW{1'b0}}};
      end
    end else if (busy_q) begin
      rem_q <= ge ? diff[RW-1:0] : rem_sh;
      q_q   <= {q_q[MW-2:0], ge};
      num_q <= (mode_q == cfs_pkg::MODE_SQRT) ? {num_q[PW-3:0], 2'b00}
                                              : {num_q[PW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

// ===== hdl/camera_follow_smoother.sv =====
// ----------------------------------------------------------------------------
// camera_follow_smoother: smoothed 2D camera follow with bounds clamp
// A sequencer drives one shared multiplier and one iterative root/divide unit.
// ----------------------------------------------------------------------------
//  channel | direction | transaction carries
//  in_i    | sink      | op, target_x, target_y
//  out_o   | source    | camera_x, camera_y, in_transition
//  cfg_i   | sink      | register index, write data (always ready)
//
// A set-snap or clear item goes straight to the output state, a tick without
// a transition runs only the clamp states and a set-with-transition item runs
// one root. A moving tick runs one root and two quotients in the iterative
// unit (only the root when the target sits on the camera), while the divides
// by 20 and 100 are reciprocal products on the multiplier.
// Input ready is high only when the sequencer is idle, so the next item can
// be taken the cycle after the result is loaded. The result waits in an
// output register, and the sequencer holds in its final state while that
// register is still full and not being taken.
// Reset is asynchronous and active low and clears camera and follow state.
// ----------------------------------------------------------------------------
module camera_follow_smoother (
  input  logic   clk_i,
  input  logic   rst_ni,
  cfs_in_if.sink    in_i,
  cfs_out_if.source out_o,
  cfs_cfg_if.sink   cfg_i
);

  localparam int CW = cfs_pkg::CAM_W;
  localparam int MW = cfs_pkg::MAG_W;
  localparam int PW = cfs_pkg::PROD_W;

  cfs_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic                         clamp_x_q, clamp_y_q;
  logic [cfs_pkg::BOUND_W-1:0]  bound_x_q, bound_y_q, half_x_q, half_y_q;
  logic [cfs_pkg::SCALE_W-1:0]  scale_x_q, scale_y_q;

  // Follow state.
  logic signed [CW-1:0] cam_x_q, cam_y_q;
  logic [MW-1:0]        start_q;
  logic                 moving_q, has_tgt_q;

  // Per item working registers.
  cfs_pkg::op_e         op_q;
  logic [MW-1:0]        ax_q, ay_q, cur_q, s1_q, step_q;
  logic                 xneg_q, yneg_q;
  logic [PW-1:0]        sum_q;

  // Result register.
  logic                 out_valid_q;
  logic signed [CW-1:0] out_x_q, out_y_q;
  logic                 out_tr_q;

  cfs_pkg::mul_req_t  mul_req;
  cfs_pkg::iter_req_t iter_req;
  logic [PW-1:0]      prod;
  logic               iter_done;
  logic [MW-1:0]      iter_q;

  cfs_mul u_mul (
    .clk_i (clk_i),
    .req_i (mul_req),
    .p_o   (prod)
  );

  cfs_iter u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (iter_req),
    .done_o (iter_done),
    .q_o    (iter_q)
  );

  logic in_fire, out_fire, out_load;
  assign in_i.ready = (state_q == cfs_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign out_load   = (state_q == cfs_pkg::ST_OUT) && (!out_valid_q || out_o.ready);
  assign cfg_i.ready = 1'b1;

  // Gap between the incoming target and the current camera, before any move.
  logic signed [MW-1:0] dx_in, dy_in;
  assign dx_in = MW'(in_i.target_x) - MW'(cam_x_q);
  assign dy_in = MW'(in_i.target_y) - MW'(cam_y_q);

  // Reciprocal products give one twentieth of the current distance and one
  // hundredth of the start distance.
  logic [MW-1:0] s1, s2;
  assign s1 = MW'(prod[PW-1:cfs_pkg::DIV20_SHIFT]);
  assign s2 = MW'(prod[PW-1:cfs_pkg::DIV100_SHIFT]);

  // End of transition: both axis gaps under one hundredth of the start distance.
  logic [31:0] ax100, ay100;
  assign ax100 = {1'b0, ax_q, 6'b0} + {2'b0, ax_q, 5'b0} + {5'b0, ax_q, 2'b0};
  assign ay100 = {1'b0, ay_q, 6'b0} + {2'b0, ay_q, 5'b0} + {5'b0, ay_q, 2'b0};

  // Apply a signed move of magnitude mag and saturate to the camera range.
  function automatic logic signed [CW-1:0] apply_move(
    input logic signed [CW-1:0] cam, input logic neg, input logic [MW-1:0] mag);
    logic signed [CW+1:0] sum;
    logic signed [CW+1:0] mv;
    mv  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    sum = (CW+2)'(cam) + mv;
    if (sum > $signed((CW+2)'(cfs_pkg::CAM_MAX))) begin
      return {1'b0, cfs_pkg::CAM_MAX};
    end else if (sum < -$signed((CW+2)'(cfs_pkg::CAM_MAX)) - 1) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return sum[CW-1:0];
  endfunction

  // Clamp one axis against the scaled level bound, inset by half the view.
  function automatic logic signed [CW-1:0] clamp_axis(
    input logic signed [CW-1:0] cam, input logic [PW-1:0] p,
    input logic [cfs_pkg::BOUND_W-1:0] half);
    logic [PW-cfs_pkg::FRAC_BITS-1:0] sbu;
    logic signed [CW+1:0] sb, c, hv;
    sbu = p[PW-1:cfs_pkg::FRAC_BITS];
    if (sbu > (PW-cfs_pkg::FRAC_BITS)'(cfs_pkg::CAM_MAX)) begin
      sb = (CW+2)'(cfs_pkg::CAM_MAX);
    end else begin
      sb = (CW+2)'(sbu);
    end
    hv = (CW+2)'(half);
    c  = (CW+2)'(cam);
    if (c < hv) begin
      c = hv;
    end
    if (c + hv > sb) begin
      c = sb - hv;
    end
    return c[CW-1:0];
  endfunction

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfs_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (cfs_pkg::op_e'(in_i.op))
            cfs_pkg::OP_SNAP, cfs_pkg::OP_CLEAR: state_d = cfs_pkg::ST_OUT;
            cfs_pkg::OP_TRANS: state_d = cfs_pkg::ST_SQX;
            cfs_pkg::OP_TICK:  state_d = moving_q ? cfs_pkg::ST_SQX : cfs_pkg::ST_CLX;
          endcase
        end
      end
      cfs_pkg::ST_SQX:   state_d = cfs_pkg::ST_SQY;
      cfs_pkg::ST_SQY:   state_d = cfs_pkg::ST_STS;
      cfs_pkg::ST_STS:   state_d = cfs_pkg::ST_WS;
      cfs_pkg::ST_WS: begin
        if (iter_done) begin
          state_d = (op_q == cfs_pkg::OP_TRANS) ? cfs_pkg::ST_OUT : cfs_pkg::ST_DIV20;
        end
      end
      cfs_pkg::ST_DIV20:  state_d = cfs_pkg::ST_DIV100;
      cfs_pkg::ST_DIV100: state_d = cfs_pkg::ST_STEP;
      cfs_pkg::ST_STEP: begin
        state_d = (cur_q == '0) ? cfs_pkg::ST_ENDC : cfs_pkg::ST_MULX;
      end
      cfs_pkg::ST_MULX:  state_d = cfs_pkg::ST_STX;
      cfs_pkg::ST_STX:   state_d = cfs_pkg::ST_WX;
      cfs_pkg::ST_WX:    if (iter_done) state_d = cfs_pkg::ST_MULY;
      cfs_pkg::ST_MULY:  state_d = cfs_pkg::ST_STY;
      cfs_pkg::ST_STY:   state_d = cfs_pkg::ST_WY;
      cfs_pkg::ST_WY:    if (iter_done) state_d = cfs_pkg::ST_ENDC;
      cfs_pkg::ST_ENDC:  state_d = cfs_pkg::ST_CLX;
      cfs_pkg::ST_CLX:   state_d = cfs_pkg::ST_CLXC;
      cfs_pkg::ST_CLXC:  state_d = cfs_pkg::ST_CLY;
      cfs_pkg::ST_CLY:   state_d = cfs_pkg::ST_CLYC;
      cfs_pkg::ST_CLYC:  state_d = cfs_pkg::ST_OUT;
      cfs_pkg::ST_OUT:   if (out_load) state_d = cfs_pkg::ST_IDLE;
      default:           state_d = cfs_pkg::ST_IDLE;
    endcase
  end

  // Requests to the shared units.
  always_comb begin
    mul_req       = '0;
    iter_req      = '0;
    iter_req.mode = cfs_pkg::MODE_DIV;
    unique case (state_q)
      cfs_pkg::ST_SQX: begin
        mul_req = '{en: 1'b1, a: ax_q, b: ax_q};
      end
      cfs_pkg::ST_SQY: begin
        mul_req = '{en: 1'b1, a: ay_q, b: ay_q};
      end
      cfs_pkg::ST_STS: begin
        iter_req.start = 1'b1;
        iter_req.mode  = cfs_pkg::MODE_SQRT;
        iter_req.num   = sum_q + prod;
      end
      cfs_pkg::ST_DIV20: begin
        mul_req = '{en: 1'b1, a: MW'(cur_q[MW-1:2]), b: cfs_pkg::RECIP_5};
      end
      cfs_pkg::ST_DIV100: begin
        mul_req = '{en: 1'b1, a: MW'(start_q[MW-1:2]), b: cfs_pkg::RECIP_25};
      end
      cfs_pkg::ST_MULX: begin
        mul_req = '{en: 1'b1, a: step_q, b: ax_q};
      end
      cfs_pkg::ST_MULY: begin
        mul_req = '{en: 1'b1, a: step_q, b: ay_q};
      end
      cfs_pkg::ST_STX, cfs_pkg::ST_STY: begin
        iter_req.start = 1'b1;
        iter_req.num   = prod;
        iter_req.den   = cur_q;
      end
      cfs_pkg::ST_CLX: begin
        mul_req = '{en: 1'b1, a: MW'(bound_x_q), b: MW'(scale_x_q)};
      end
      cfs_pkg::ST_CLY: begin
        mul_req = '{en: 1'b1, a: MW'(bound_y_q), b: MW'(scale_y_q)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfs_pkg::ST_IDLE;
      clamp_x_q   <= 1'b0;
      clamp_y_q   <= 1'b0;
      bound_x_q   <= '0;
      bound_y_q   <= '0;
      scale_x_q   <= cfs_pkg::SCALE_W'(256);
      scale_y_q   <= cfs_pkg::SCALE_W'(256);
      half_x_q    <= '0;
      half_y_q    <= '0;
      cam_x_q     <= '0;
      cam_y_q     <= '0;
      start_q     <= '0;
      moving_q    <= 1'b0;
      has_tgt_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfs_pkg::cfg_idx_e'(cfg_i.index))
          cfs_pkg::REG_CLAMP_X: clamp_x_q <= cfg_i.data[0];
          cfs_pkg::REG_CLAMP_Y: clamp_y_q <= cfg_i.data[0];
          cfs_pkg::REG_BOUND_X: bound_x_q <= cfg_i.data;
          cfs_pkg::REG_BOUND_Y: bound_y_q <= cfg_i.data;
          cfs_pkg::REG_SCALE_X: scale_x_q <= cfg_i.data[cfs_pkg::SCALE_W-1:0];
          cfs_pkg::REG_SCALE_Y: scale_y_q <= cfg_i.data[cfs_pkg::SCALE_W-1:0];
          cfs_pkg::REG_HALF_X:  half_x_q  <= cfg_i.data;
          cfs_pkg::REG_HALF_Y:  half_y_q  <= cfg_i.data;
        endcase
      end

      unique case (state_q)
        cfs_pkg::ST_IDLE: begin
          if (in_fire) begin
            unique case (cfs_pkg::op_e'(in_i.op))
              cfs_pkg::OP_SNAP: begin
                has_tgt_q <= 1'b1;
                moving_q  <= 1'b0;
              end
              cfs_pkg::OP_CLEAR: begin
                has_tgt_q <= 1'b0;
                moving_q  <= 1'b0;
              end
              cfs_pkg::OP_TRANS: begin
                has_tgt_q <= 1'b1;
              end
              cfs_pkg::OP_TICK: begin
                // Without a transition, and with a target set, the camera jumps straight to the target.
                if (!moving_q && has_tgt_q) begin
                  cam_x_q <= in_i.target_x;
                  cam_y_q <= in_i.target_y;
                end
              end
            endcase
          end
        end
        cfs_pkg::ST_WS: begin
          if (iter_done && op_q == cfs_pkg::OP_TRANS) begin
            start_q  <= iter_q;
            moving_q <= (iter_q != '0);
          end
        end
        cfs_pkg::ST_WX: begin
          if (iter_done) cam_x_q <= apply_move(cam_x_q, xneg_q, iter_q);
        end
        cfs_pkg::ST_WY: begin
          if (iter_done) cam_y_q <= apply_move(cam_y_q, yneg_q, iter_q);
        end
        cfs_pkg::ST_ENDC: begin
          if (ax100 < 32'(start_q) && ay100 < 32'(start_q)) begin
            moving_q <= 1'b0;
          end
        end
        cfs_pkg::ST_CLXC: begin
          if (clamp_x_q) cam_x_q <= clamp_axis(cam_x_q, prod, half_x_q);
        end
        cfs_pkg::ST_CLYC: begin
          if (clamp_y_q) cam_y_q <= clamp_axis(cam_y_q, prod, half_y_q);
        end
        default: begin
        end
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and result payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= cfs_pkg::op_e'(in_i.op);
      ax_q   <= dx_in[MW-1] ? -dx_in : dx_in;
      ay_q   <= dy_in[MW-1] ? -dy_in : dy_in;
      xneg_q <= dx_in[MW-1];
      yneg_q <= dy_in[MW-1];
    end
    if (state_q == cfs_pkg::ST_SQY) begin
      sum_q <= prod;
    end
    if (state_q == cfs_pkg::ST_WS && iter_done) begin
      cur_q <= iter_q;
    end
    if (state_q == cfs_pkg::ST_DIV100) begin
      s1_q <= s1;
    end
    if (state_q == cfs_pkg::ST_STEP) begin
      step_q <= (s1_q > s2) ? s1_q : s2;
    end
    if (out_load) begin
      out_x_q  <= cam_x_q;
      out_y_q  <= cam_y_q;
      out_tr_q <= moving_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.camera_x      = out_x_q;
  assign out_o.camera_y      = out_y_q;
  assign out_o.in_transition = out_tr_q;

endmodule
